// ===== hw/rtl/rmm_pkg.sv =====
package rmm_pkg;

   // Audio framing
   localparam int SAMPLE_RATE      = 48000;
   localparam int WRAP_SECONDS     = 5;
   localparam int SINE_TABLE_DEPTH = 1024;

   localparam int TICK_WRAP = SAMPLE_RATE * WRAP_SECONDS;
   localparam int TICK_W    = $clog2(TICK_WRAP + 1);
   localparam int PHASE_W   = $clog2(SAMPLE_RATE);
   localparam int IDX_W     = $clog2(SINE_TABLE_DEPTH);
   localparam int NUM_W     = $clog2(SAMPLE_RATE * SINE_TABLE_DEPTH);

   // Field widths
   localparam int SAMPLE_W = 16;
   localparam int GAIN_W   = 16;
   localparam int FREQ_W   = 15;
   localparam int TAB_W    = 16;

   localparam int GAIN_ONE = 32768;
   localparam int FREQ_MAX = SAMPLE_RATE / 2;
   localparam int FCMP_W   = ((FREQ_W > PHASE_W) ? FREQ_W : PHASE_W) + 1;

   // CSR port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_MIX_GAIN   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CARRIER_HZ = 2'd1;
   localparam logic [GAIN_W-1:0] MIX_GAIN_RST   = 16'd16384;
   localparam logic [FREQ_W-1:0] CARRIER_HZ_RST = 15'd1000;

   // Shared multiplier
   localparam int MUL_A_W = 32;
   localparam int MUL_B_W = 21;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;

   // Phase-to-index divide: q ~= (n * RECIP_MUL) >> RECIP_SHIFT, off by at most one low
   localparam int RECIP_SHIFT = 32;
   localparam longint unsigned RECIP_MUL = (64'd1 << RECIP_SHIFT) / SAMPLE_RATE;

   // Output scaling
   localparam int Q30_SHIFT = 30;

   typedef struct packed {
      logic [GAIN_W-1:0]  gain;   // saturated to 1.0
      logic [PHASE_W-1:0] freq;   // saturated to Nyquist
   } cfg_type;

   typedef struct packed {
      logic                      en;
      logic signed [MUL_A_W-1:0] a;
      logic signed [MUL_B_W-1:0] b;
   } mul_req_type;

   typedef logic [SINE_TABLE_DEPTH-1:0][TAB_W-1:0] sine_tab_type;

   localparam logic [63:0] Q30_ONE     = 64'd1073741824;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   // Half-amplitude sine, Q1.15, odd Taylor series to x^11 on a quarter wave
   function automatic sine_tab_type build_sine_tab();
      sine_tab_type tab;
      logic [63:0]  f;
      logic [63:0]  r;
      logic [63:0]  x;
      logic [63:0]  x2;
      logic [63:0]  t;
      logic [63:0]  s;
      logic [63:0]  v;
      logic [1:0]   quad;
      for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
         f    = (64'(k) << 32) / 64'(SINE_TABLE_DEPTH);
         quad = f[31:30];
         r    = f & (Q30_ONE - 64'd1);
         if (quad[0]) begin
            r = Q30_ONE - r;
         end
         x  = (r * HALF_PI_Q30) >> 30;
         x2 = (x * x) >> 30;
         t  = Q30_ONE - x2 / 64'd110;
         t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
         t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
         t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
         t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
         s  = (x * t) >> 30;
         v  = (s * 64'd16384 + (Q30_ONE >> 1)) >> 30;
         tab[k] = quad[1] ? (16'd0 - v[TAB_W-1:0]) : v[TAB_W-1:0];
      end
      return tab;
   endfunction

   localparam sine_tab_type SINE_TAB = build_sine_tab();

endpackage

// ===== hw/rtl/rmm_if.sv =====
interface rmm_req_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [rmm_pkg::SAMPLE_W-1:0]   left_sample;
   logic signed [rmm_pkg::SAMPLE_W-1:0]   right_sample;

   modport source (output valid, output left_sample, output right_sample, input ready);
   modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

interface rmm_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [rmm_pkg::SAMPLE_W-1:0]   mixed_sample;

   modport source (output valid, output mixed_sample, input ready);
   modport sink   (input valid, input mixed_sample, output ready);
endinterface

interface rmm_csr_if;
   logic                                  valid;
   logic                                  ready;
   logic [rmm_pkg::CSR_IDX_W-1:0]         index;
   logic [rmm_pkg::CSR_DATA_W-1:0]        data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/rmm_mul.sv =====
module rmm_mul (
   input  logic                                   clock,
   input  rmm_pkg::mul_req_type                   req,
   output logic signed [rmm_pkg::PROD_W-1:0]      prod
);

   logic signed [rmm_pkg::PROD_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      if (req.en) begin
         prod_ff <= rmm_pkg::PROD_W'(req.a) * rmm_pkg::PROD_W'(req.b);
      end
   end

   assign prod = prod_ff;

endmodule

// ===== hw/rtl/rmm_sine_rom.sv =====
module rmm_sine_rom (
   input  logic                                clock,
   input  logic [rmm_pkg::IDX_W-1:0]           addr,
   output logic signed [rmm_pkg::TAB_W-1:0]    rd_data
);

   logic signed [rmm_pkg::TAB_W-1:0] rd_data_ff;

   // registered read, maps to a block ROM
   always_ff @(posedge clock) begin
      rd_data_ff <= $signed(rmm_pkg::SINE_TAB[addr]);
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/rmm_csr.sv =====
module rmm_csr (
   input  logic               clock,
   input  logic               reset,
   rmm_csr_if.sink            csr,
   output rmm_pkg::cfg_type   cfg
);

   logic [rmm_pkg::GAIN_W-1:0] mix_gain_ff;
   logic [rmm_pkg::GAIN_W-1:0] mix_gain_in;
   logic [rmm_pkg::FREQ_W-1:0] carrier_hz_ff;
   logic [rmm_pkg::FREQ_W-1:0] carrier_hz_in;
   logic [rmm_pkg::FCMP_W-1:0] hz_ext;

   assign csr.ready = 1'b1;

   always_comb begin
      mix_gain_in   = mix_gain_ff;
      carrier_hz_in = carrier_hz_ff;
      if (csr.valid) begin
         case (csr.index)
            rmm_pkg::CSR_MIX_GAIN: begin
               mix_gain_in = csr.data[rmm_pkg::GAIN_W-1:0];
            end
            rmm_pkg::CSR_CARRIER_HZ: begin
               carrier_hz_in = csr.data[rmm_pkg::FREQ_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mix_gain_ff   <= rmm_pkg::MIX_GAIN_RST;
         carrier_hz_ff <= rmm_pkg::CARRIER_HZ_RST;
      end else begin
         mix_gain_ff   <= mix_gain_in;
         carrier_hz_ff <= carrier_hz_in;
      end
   end

   // saturate gain to 1.0 and frequency to Nyquist
   assign hz_ext = rmm_pkg::FCMP_W'(carrier_hz_ff);

   always_comb begin
      if (mix_gain_ff > rmm_pkg::GAIN_W'(rmm_pkg::GAIN_ONE)) begin
         cfg.gain = rmm_pkg::GAIN_W'(rmm_pkg::GAIN_ONE);
      end else begin
         cfg.gain = mix_gain_ff;
      end
      if (hz_ext > rmm_pkg::FCMP_W'(rmm_pkg::FREQ_MAX)) begin
         cfg.freq = rmm_pkg::PHASE_W'(rmm_pkg::FREQ_MAX);
      end else begin
         cfg.freq = rmm_pkg::PHASE_W'(hz_ext);
      end
   end

endmodule

// ===== hw/rtl/ring_modulator_mix_top.sv =====
// Ring modulator: mono mix of a stereo pair, multiplied by a sine carrier.
//
// req_ch : one word per audio frame, left_sample and right_sample (signed 16).
// rsp_ch : one word per frame, mixed_sample (signed 16), dry/wet mix of the
//          mono sample with the carrier product, gain set by mix_gain.
// csr_ch : register writes, index 0 = mix_gain (Q1.15), 1 = carrier_hz.
//          Always ready; write only while no frame is in flight.
//
// Timing: rsp_ch.valid rises when the last step fills the output register.
// req_ch.ready is high only while the sequencer is idle, so the block takes no
// new word until its steps are done: four passes through the single shared
// 32x21 multiplier (phase-to-index reciprocal, remainder check, gain, wet
// product), the index fix, one registered sine ROM read, scale/clamp and idle.
// rsp_ch has its own output register: the next frame is accepted while a
// result waits. If the receiver stalls, the sequencer holds in its last
// step until the output register frees, then returns to idle.
// Reset: sample counter and carrier phase clear, mix_gain = 0.5,
// carrier_hz = 1000, no result pending. The sine ROM is constant.
module ring_modulator_mix_top (
   input  logic          clock,
   input  logic          reset,
   rmm_req_if.sink       req_ch,
   rmm_rsp_if.source     rsp_ch,
   rmm_csr_if.sink       csr_ch
);

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_RECIP = 8'b0000_0010,   // n * 1/Fs
      ST_QFIX  = 8'b0000_0100,   // q_est * Fs for remainder
      ST_CORR  = 8'b0000_1000,   // fix q, issue ROM address
      ST_ROM   = 8'b0001_0000,   // ROM read
      ST_GAIN  = 8'b0010_0000,   // g * (c - 1.0)
      ST_WET   = 8'b0100_0000,   // s * (1.0 + g*(c-1.0))
      ST_DONE  = 8'b1000_0000    // scale, clamp, hand to output reg
   } state_type;

   localparam int SUM_W = rmm_pkg::SAMPLE_W + 1;
   localparam int Y_W   = rmm_pkg::PROD_W - rmm_pkg::Q30_SHIFT;

   state_type state_ff;
   state_type state_in;

   logic [rmm_pkg::TICK_W-1:0]           tick_ff;
   logic [rmm_pkg::TICK_W-1:0]           tick_in;
   logic [rmm_pkg::PHASE_W-1:0]          phase_ff;
   logic [rmm_pkg::PHASE_W-1:0]          phase_in;
   logic signed [rmm_pkg::SAMPLE_W-1:0]  s_ff;
   logic signed [rmm_pkg::SAMPLE_W-1:0]  s_in;
   logic [rmm_pkg::IDX_W-1:0]            q_ff;
   logic [rmm_pkg::IDX_W-1:0]            q_in;
   logic [rmm_pkg::IDX_W-1:0]            idx_ff;
   logic [rmm_pkg::IDX_W-1:0]            idx_in;
   logic                                 rsp_valid_ff;
   logic                                 rsp_valid_in;
   logic signed [rmm_pkg::SAMPLE_W-1:0]  rsp_data_ff;
   logic signed [rmm_pkg::SAMPLE_W-1:0]  rsp_data_in;

   rmm_pkg::cfg_type                     cfg;
   rmm_pkg::mul_req_type                 mul_req;
   logic signed [rmm_pkg::PROD_W-1:0]    prod;
   logic signed [rmm_pkg::TAB_W-1:0]     carrier;

   logic                                 req_fire;
   logic                                 out_free;
   logic signed [SUM_W-1:0]              pair_sum;
   logic [rmm_pkg::PHASE_W:0]            phase_sum;
   logic [rmm_pkg::NUM_W-1:0]            num;
   logic [rmm_pkg::NUM_W:0]              rem;
   logic signed [rmm_pkg::PROD_W-1:0]    acc_b;
   logic signed [Y_W-1:0]                y_full;
   logic signed [rmm_pkg::SAMPLE_W-1:0]  y_sat;

   rmm_csr u_csr (
      .clock (clock),
      .reset (reset),
      .csr   (csr_ch),
      .cfg   (cfg)
   );

   rmm_mul u_mul (
      .clock (clock),
      .req   (mul_req),
      .prod  (prod)
   );

   rmm_sine_rom u_rom (
      .clock   (clock),
      .addr    (idx_ff),
      .rd_data (carrier)
   );

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_ch.valid && (state_ff == ST_IDLE);
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.mixed_sample = rsp_data_ff;

   // mono average, truncated toward zero
   assign pair_sum  = SUM_W'(req_ch.left_sample) + SUM_W'(req_ch.right_sample);
   assign phase_sum = {1'b0, phase_ff} + {1'b0, cfg.freq};

   // phase scaled to table units, numerator of the index divide
   assign num = rmm_pkg::NUM_W'(phase_ff) * rmm_pkg::NUM_W'(rmm_pkg::SINE_TABLE_DEPTH);
   assign rem = {1'b0, num} - prod[rmm_pkg::NUM_W:0];

   // acc / 2^30 toward zero, then clamp
   assign acc_b  = prod + (prod[rmm_pkg::PROD_W-1] ?
                   rmm_pkg::PROD_W'((64'd1 << rmm_pkg::Q30_SHIFT) - 64'd1) :
                   rmm_pkg::PROD_W'(0));
   assign y_full = Y_W'(acc_b >>> rmm_pkg::Q30_SHIFT);

   always_comb begin
      if (y_full > Y_W'(32767)) begin
         y_sat = 16'sh7FFF;
      end else if (y_full < -Y_W'(32768)) begin
         y_sat = -16'sh8000;
      end else begin
         y_sat = y_full[rmm_pkg::SAMPLE_W-1:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      tick_in      = tick_ff;
      phase_in     = phase_ff;
      s_in         = s_ff;
      q_in         = q_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_data_in  = rsp_data_ff;
      mul_req      = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               s_in = rmm_pkg::SAMPLE_W'((pair_sum + SUM_W'(pair_sum[SUM_W-1])) >>> 1);
               if (tick_ff >= rmm_pkg::TICK_W'(rmm_pkg::TICK_WRAP)) begin
                  tick_in  = '0;
                  phase_in = '0;
               end else begin
                  tick_in = tick_ff + 1'b1;
                  if (phase_sum >= (rmm_pkg::PHASE_W + 1)'(rmm_pkg::SAMPLE_RATE)) begin
                     phase_in = rmm_pkg::PHASE_W'(phase_sum -
                                (rmm_pkg::PHASE_W + 1)'(rmm_pkg::SAMPLE_RATE));
                  end else begin
                     phase_in = rmm_pkg::PHASE_W'(phase_sum);
                  end
               end
               state_in = ST_RECIP;
            end
         end
         ST_RECIP: begin
            mul_req.en = 1'b1;
            mul_req.a  = rmm_pkg::MUL_A_W'(num);
            mul_req.b  = rmm_pkg::MUL_B_W'(rmm_pkg::RECIP_MUL);
            state_in   = ST_QFIX;
         end
         ST_QFIX: begin
            q_in       = prod[rmm_pkg::RECIP_SHIFT +: rmm_pkg::IDX_W];
            mul_req.en = 1'b1;
            mul_req.a  = rmm_pkg::MUL_A_W'(prod[rmm_pkg::RECIP_SHIFT +: rmm_pkg::IDX_W]);
            mul_req.b  = rmm_pkg::MUL_B_W'(rmm_pkg::SAMPLE_RATE);
            state_in   = ST_CORR;
         end
         ST_CORR: begin
            // estimate is low by at most one
            if (rem >= (rmm_pkg::NUM_W + 1)'(rmm_pkg::SAMPLE_RATE)) begin
               idx_in = q_ff + 1'b1;
            end else begin
               idx_in = q_ff;
            end
            state_in = ST_ROM;
         end
         ST_ROM: begin
            state_in = ST_GAIN;
         end
         ST_GAIN: begin
            mul_req.en = 1'b1;
            mul_req.a  = rmm_pkg::MUL_A_W'(carrier) -
                         rmm_pkg::MUL_A_W'(rmm_pkg::GAIN_ONE);
            mul_req.b  = rmm_pkg::MUL_B_W'(cfg.gain);
            state_in   = ST_WET;
         end
         ST_WET: begin
            // (1-g)*1.0 + g*c = 1.0 + g*(c-1.0), fits 32 bits signed
            mul_req.en = 1'b1;
            mul_req.a  = prod[rmm_pkg::MUL_A_W-1:0] +
                         rmm_pkg::MUL_A_W'(64'd1 << rmm_pkg::Q30_SHIFT);
            mul_req.b  = rmm_pkg::MUL_B_W'(s_ff);
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = y_sat;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tick_ff      <= '0;
         phase_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tick_ff      <= tick_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s_ff        <= s_in;
      q_ff        <= q_in;
      idx_ff      <= idx_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ===== tb/sv/ring_modulator_mix_top_tb.sv =====
`timescale 1ns / 1ps

module ring_modulator_mix_top_tb;

   // Fixed-point scale used by both the sine table build and the output shift
   localparam longint Q30_SCALE = 64'sd1073741824;
   localparam longint HALF_PI_SCALED = 64'sd1686629713;

   // Register indexes the block does not decode; writes there must be dropped
   localparam logic [rmm_pkg::CSR_IDX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [rmm_pkg::CSR_IDX_W-1:0] CSR_SPARE_3 = 2'd3;

   localparam int NUM_SETTINGS = 9;
   localparam int WORDS_PER_SETTING = 220;
   localparam int DIRECTED_WORDS = 16;

   typedef enum {RX_OPEN, RX_COIN, RX_CHOKE} rx_mode_type;

   // ------------------------------------------------------------------
   // Tracks gain/frequency registers, tick counter and carrier phase,
   // and keeps the queue of mixed samples the block still owes us.
   // ------------------------------------------------------------------
   class mix_tracker_type;
      int unsigned gain_reg;
      int unsigned hz_reg;
      int unsigned tick;
      int unsigned phase;
      int sine_lut[rmm_pkg::SINE_TABLE_DEPTH];
      logic signed [rmm_pkg::SAMPLE_W-1:0] pending_mix[$];
      int unsigned mismatches;
      int unsigned checked;

      function new();
         gain_reg = rmm_pkg::MIX_GAIN_RST;
         hz_reg = rmm_pkg::CARRIER_HZ_RST;
         tick = 0;
         phase = 0;
         mismatches = 0;
         checked = 0;
         for (int k = 0; k < rmm_pkg::SINE_TABLE_DEPTH; k++) begin
            sine_lut[k] = sine_entry(k);
         end
      endfunction

      // Half-amplitude sine, Q1.15: odd polynomial to x^11 on a quarter wave,
      // mirrored for quadrants 1 and 3, negated for quadrants 2 and 3.
      function int sine_entry(int k);
         longint unsigned frac;
         longint unsigned r;
         longint unsigned x;
         longint unsigned x2;
         longint unsigned t;
         longint unsigned s;
         int quad;
         int mag;
         frac = (longint'(k) << 32) / rmm_pkg::SINE_TABLE_DEPTH;
         quad = int'((frac >> 30) & 3);
         r = frac & (Q30_SCALE - 1);
         if (quad % 2 == 1) begin
            r = Q30_SCALE - r;
         end
         x = (r * HALF_PI_SCALED) >> 30;
         x2 = (x * x) >> 30;
         t = Q30_SCALE - x2 / 110;
         t = Q30_SCALE - ((x2 * t) >> 30) / 72;
         t = Q30_SCALE - ((x2 * t) >> 30) / 42;
         t = Q30_SCALE - ((x2 * t) >> 30) / 20;
         t = Q30_SCALE - ((x2 * t) >> 30) / 6;
         s = (x * t) >> 30;
         mag = int'((s * 16384 + (Q30_SCALE >> 1)) >> 30);
         return (quad >= 2) ? -mag : mag;
      endfunction

      function void write_reg(logic [rmm_pkg::CSR_IDX_W-1:0] idx,
                              logic [rmm_pkg::CSR_DATA_W-1:0] data);
         if (idx == rmm_pkg::CSR_MIX_GAIN) begin
            gain_reg = data;
         end else if (idx == rmm_pkg::CSR_CARRIER_HZ) begin
            hz_reg = data[rmm_pkg::FREQ_W-1:0];
         end
      endfunction

      // One accepted frame: advance counter/phase, then mix
      function void note_frame(logic signed [rmm_pkg::SAMPLE_W-1:0] left,
                               logic signed [rmm_pkg::SAMPLE_W-1:0] right);
         int mono;
         int unsigned g;
         int unsigned f;
         int unsigned idx;
         longint acc;
         longint y;
         mono = (int'(left) + int'(right)) / 2;
         g = (gain_reg > rmm_pkg::GAIN_ONE) ? rmm_pkg::GAIN_ONE : gain_reg;
         f = (hz_reg > rmm_pkg::FREQ_MAX) ? rmm_pkg::FREQ_MAX : hz_reg;
         if (tick >= rmm_pkg::TICK_WRAP) begin
            tick = 0;
            phase = 0;
         end else begin
            tick++;
            phase += f;
            if (phase >= rmm_pkg::SAMPLE_RATE) begin
               phase -= rmm_pkg::SAMPLE_RATE;
            end
         end
         idx = int'((longint'(phase) * rmm_pkg::SINE_TABLE_DEPTH) / rmm_pkg::SAMPLE_RATE);
         if (idx >= rmm_pkg::SINE_TABLE_DEPTH) begin
            idx = rmm_pkg::SINE_TABLE_DEPTH - 1;
         end
         acc = longint'(rmm_pkg::GAIN_ONE - int'(g)) * mono * rmm_pkg::GAIN_ONE
             + longint'(g) * mono * sine_lut[idx];
         y = acc / Q30_SCALE;
         if (y > 32767) begin
            y = 32767;
         end
         if (y < -32768) begin
            y = -32768;
         end
         pending_mix.push_back(rmm_pkg::SAMPLE_W'(y));
      endfunction

      function void check_mix(logic signed [rmm_pkg::SAMPLE_W-1:0] actual);
         logic signed [rmm_pkg::SAMPLE_W-1:0] expected;
         checked++;
         if (pending_mix.size() == 0) begin
            mismatches++;
            $display("%0t: mixed_sample with no frame waiting, expected none, actual %0d",
                     $time, actual);
         end else begin
            expected = pending_mix.pop_front();
            if (actual !== expected) begin
               mismatches++;
               $display("%0t: mixed_sample mismatch, expected %0d, actual %0d",
                        $time, expected, actual);
            end
         end
      endfunction

      function void close_out();
         if (pending_mix.size() != 0) begin
            mismatches += pending_mix.size();
            $display("%0t: %0d expected mixed_sample words never arrived, next expected %0d",
                     $time, pending_mix.size(), pending_mix[0]);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   rmm_req_if req_if();
   rmm_rsp_if rsp_if();
   rmm_csr_if csr_if();

   ring_modulator_mix_top i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   always #5 clock = ~clock;

   mix_tracker_type tracker = new();

   // Sender pacing: bursts of back-to-back words, random gaps between bursts
   int unsigned burst_left = 0;
   bit steady_sender = 1'b0;
   int unsigned frames_sent = 0;

   // Receiver stall pattern state
   rx_mode_type rx_mode = RX_OPEN;
   int unsigned rx_window = 0;
   int unsigned rx_hold = 0;
   logic rx_level = 1'b1;

   // Directed frames: full-scale corners, sign mixes, and odd sums of both
   // signs to catch truncation toward zero in the mono average
   logic signed [rmm_pkg::SAMPLE_W-1:0] dir_left [DIRECTED_WORDS] = '{
      0, 32767, -32768, 32767, -32768, 1, -1, -3,
      3, -1, 32767, -32768, 16'h5555, 16'hAAAA, 1234, -1
   };
   logic signed [rmm_pkg::SAMPLE_W-1:0] dir_right [DIRECTED_WORDS] = '{
      0, 32767, -32768, -32768, 32767, 0, 0, 0,
      0, -2, 32766, -32767, 16'hAAAA, 16'h5555, -5678, -1
   };

   // Register settings per phase: dry, full wet at Nyquist, both registers
   // past their caps, one past the caps, static carrier, minimum values,
   // one below the caps, then two random settings
   int unsigned phase_gain [NUM_SETTINGS] = '{0, 32768, 65535, 32769, 16384, 1, 32767, 0, 0};
   int unsigned phase_hz [NUM_SETTINGS] = '{1000, 24000, 65535, 24001, 0, 1, 23999, 0, 0};

   // Mostly full random words, with a bias toward the rails and near zero
   function automatic logic signed [rmm_pkg::SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 9))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         2: return rmm_pkg::SAMPLE_W'(int'($urandom_range(0, 8)) - 4);
         default: return rmm_pkg::SAMPLE_W'($urandom);
      endcase
   endfunction

   // Present one frame word, hold it until taken, then maybe idle a while
   task automatic send_frame(input logic signed [rmm_pkg::SAMPLE_W-1:0] left,
                             input logic signed [rmm_pkg::SAMPLE_W-1:0] right);
      int unsigned gap;
      req_if.valid <= 1'b1;
      req_if.left_sample <= left;
      req_if.right_sample <= right;
      @(posedge clock);
      while (!req_if.ready) begin
         @(posedge clock);
      end
      tracker.note_frame(left, right);
      frames_sent++;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         gap = steady_sender ? 0 : $urandom_range(0, 12);
         if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   // Leaves csr valid high; the caller drops it after the last write
   task automatic write_csr(input logic [rmm_pkg::CSR_IDX_W-1:0] idx,
                            input logic [rmm_pkg::CSR_DATA_W-1:0] data);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data <= data;
      @(posedge clock);
      while (!csr_if.ready) begin
         @(posedge clock);
      end
      tracker.write_reg(idx, data);
   endtask

   // Stop sending, wait for every owed word, then let the sequencer settle in idle
   // before touching registers
   task automatic quiesce();
      req_if.valid <= 1'b0;
      while (tracker.pending_mix.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   // Result monitor and receiver stall pattern. ready is sampled before the
   // edge's updates land, so the check sees the handshake as the block did.
   always @(posedge clock) begin
      if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         tracker.check_mix(rsp_if.mixed_sample);
      end
      if (rx_window == 0) begin
         rx_mode = rx_mode_type'($urandom_range(0, 2));
         rx_window = $urandom_range(40, 300);
      end else begin
         rx_window--;
      end
      if (rx_hold == 0) begin
         case (rx_mode)
            RX_OPEN: begin
               rx_level = 1'b1;
               rx_hold = 8;
            end
            RX_COIN: begin
               rx_level = $urandom_range(0, 1);
               rx_hold = 0;
            end
            default: begin
               // long stalls with short open windows
               rx_level = !rx_level;
               rx_hold = rx_level ? $urandom_range(0, 5) : $urandom_range(0, 23);
            end
         endcase
      end else begin
         rx_hold--;
      end
      rsp_if.ready <= rx_level;
   end

   initial begin
      int unsigned gain_w;
      int unsigned hz_w;
      req_if.valid = 1'b0;
      req_if.left_sample = '0;
      req_if.right_sample = '0;
      csr_if.valid = 1'b0;
      csr_if.index = rmm_pkg::CSR_MIX_GAIN;
      csr_if.data = '0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed corners under the reset register values
      for (int i = 0; i < DIRECTED_WORDS; i++) begin
         send_frame(dir_left[i], dir_right[i]);
      end

      for (int p = 0; p < NUM_SETTINGS; p++) begin
         quiesce();
         gain_w = phase_gain[p];
         hz_w = phase_hz[p];
         if (p >= NUM_SETTINGS - 2) begin
            gain_w = $urandom_range(0, 65535);
            hz_w = $urandom_range(0, rmm_pkg::FREQ_MAX);
         end
         // undecoded index first: must leave both registers alone
         write_csr((p % 2 == 1) ? CSR_SPARE_3 : CSR_SPARE_2, rmm_pkg::CSR_DATA_W'($urandom));
         write_csr(rmm_pkg::CSR_MIX_GAIN, rmm_pkg::CSR_DATA_W'(gain_w));
         write_csr(rmm_pkg::CSR_CARRIER_HZ, rmm_pkg::CSR_DATA_W'(hz_w));
         csr_if.valid <= 1'b0;

         // two settings run with the sender never idling
         steady_sender = (p == 2 || p == 6);
         repeat (WORDS_PER_SETTING) send_frame(pick_sample(), pick_sample());
      end

      quiesce();
      repeat (16) @(posedge clock);
      tracker.close_out();

      $display("Summary: %0d frames over %0d register settings plus reset values",
               frames_sent, NUM_SETTINGS);
      $display("Summary: dry, full wet, capped registers, static carrier, spare index; %0d checked",
               tracker.checked);
      if (tracker.mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // Watchdog, far past the slowest legal run
   initial begin
      #5_000_000;
      $display("%0t: watchdog expired with %0d words outstanding", $time,
               tracker.pending_mix.size());
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
